/* hdl/assert_macros.svh */
// Assertion macros used by the linearizer RTL.
// Clocked on aclk; the checking form drops out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define NTCL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ntcl assertion failed");
// Check a property at every edge, reset included.
`define NTCL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("ntcl assertion failed");
`else
`define NTCL_ASSERT(lbl, prop)
`define NTCL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* hdl/ntcl_pkg.sv */
`timescale 1ns / 1ps
// Package for the NTC linearizer: widths, the thermistor table, scaling constants
// and the side-band type carried through the dividers. No dependencies.
package ntcl_pkg;

    localparam int TABLE_ENTRIES = 21;
    localparam int ADC_CODES     = 1024;
    localparam int ADC_SHIFT     = $clog2(ADC_CODES);

    localparam int CODE_W = 10;
    localparam int VREF_W = 13;
    localparam int RDIV_W = 30;
    localparam int TEMP_W = 15;
    localparam int MV_W   = 13;
    localparam int NUM_W  = 43;
    localparam int DEN_W  = 23;
    localparam int QUO_W  = 34;
    localparam int REM_W  = DEN_W + 1;
    localparam int OHM_W  = 21;
    localparam int SEG_W  = $clog2(TABLE_ENTRIES);
    localparam int H_W    = 20;
    localparam int V_W    = 24;
    localparam int RCP_W  = 29;
    localparam int PROD_W = V_W - 1 + RCP_W;
    localparam int RCP_SHIFT = 32;
    localparam int MAG_W  = PROD_W - RCP_SHIFT;
    localparam int QC_W   = 18;

    localparam int DEN_SCALE   = 1000;
    localparam int SLOPE_SCALE = 500;
    localparam int Q_CLAMP     = 250000;

    localparam logic signed [H_W-1:0] HUND_S  = 100;
    localparam logic signed [V_W-1:0] NINE_S  = 9;
    localparam logic signed [V_W-1:0] F_OFF_S = 16000;
    localparam logic signed [MAG_W:0] LIMIT_S = 9999;

    // ceil(2^32 / 10) and ceil(2^32 / 50): exact for magnitudes below 2^30
    localparam logic [RCP_W-1:0] RCP_TENTHS = 29'd429496730;
    localparam logic [RCP_W-1:0] RCP_FAHR   = 29'd85899346;

    localparam logic [VREF_W-1:0] VREF_RESET = 13'd3000;
    localparam logic [RDIV_W-1:0] RDIV_RESET = 30'd470000000;

    typedef enum logic [1:0] {
        CFG_VREF = 2'd0,
        CFG_RDIV = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic             func;
        logic             cold;
        logic             hot;
        logic             neg;
        logic [SEG_W-1:0] seg;
    } side_t;

    localparam logic [OHM_W-1:0] RT_OHM [TABLE_ENTRIES] = '{
        21'd1344300, 21'd998530, 21'd748670, 21'd566360, 21'd432120, 21'd332400,
        21'd257690, 21'd201270, 21'd158340, 21'd125420, 21'd100000, 21'd80239,
        21'd64776, 21'd52598, 21'd42950, 21'd35262, 21'd29100, 21'd24136,
        21'd20114, 21'd16841, 21'd14164
    };

    localparam logic signed [7:0] RT_DEG [TABLE_ENTRIES] = '{
        -8'sd25, -8'sd20, -8'sd15, -8'sd10, -8'sd5, 8'sd0, 8'sd5, 8'sd10, 8'sd15,
        8'sd20, 8'sd25, 8'sd30, 8'sd35, 8'sd40, 8'sd45, 8'sd50, 8'sd55, 8'sd60,
        8'sd65, 8'sd70, 8'sd75
    };

endpackage

/* hdl/ntc_thermistor_linearizer_top.sv */
`timescale 1ns / 1ps
// NTC thermistor linearizer, top level. Uses ntcl_pkg, ntcl_front, ntcl_div,
// ntcl_interp, ntcl_convert and assert_macros.svh.
//
// Input words (s_*): tdata[9:0] is the ADC code at the divider midpoint,
// tuser[0] picks the unit (0 Celsius tenths, 1 Fahrenheit tenths).
// Result words (m_*): tdata[14:0] is the signed temperature in tenths,
// tuser[0] flags a limit value (+9999 hot end, -9999 open or too cold).
// Exactly one result word per input word, in order.
// From acceptance to m_tvalid a word passes two front stages, two 34-stage
// bit-per-stage dividers (resistance, then slope), two table stages and four
// conversion stages. One word is accepted every cycle that the pipeline advances.
// The whole pipeline advances together: when m_tvalid is high and m_tready is
// low it holds and s_tready drops, nothing is lost or repeated.
// Reset empties the pipeline and loads 3000 mV and 470000000 milliohm into
// the two configuration registers; write them with cfg_wr_en while idle.
`include "assert_macros.svh"

module ntc_thermistor_linearizer_top import ntcl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [RDIV_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [9:0] adc_code, [15:10] zero
    input  logic [0:0]        s_tuser,   // [0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [14:0] temperature_tenths, [15] zero
    output logic [0:0]        m_tuser    // [0] out_of_range
);

    logic [VREF_W-1:0] vref_reg;
    logic [RDIV_W-1:0] rdiv_reg;
    logic              en;

    logic              f_valid;
    logic [NUM_W-1:0]  f_dividend;
    logic [DEN_W-1:0]  f_divisor;
    side_t             f_side;

    logic              r_valid;
    logic [QUO_W-1:0]  r_ohm;
    side_t             r_side;

    logic              i_valid;
    logic [NUM_W-1:0]  i_dividend;
    logic [DEN_W-1:0]  i_divisor;
    side_t             i_side;

    logic              q_valid;
    logic [QUO_W-1:0]  q_quot;
    side_t             q_side;

    logic [TEMP_W-1:0] temp;
    logic              oor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg <= VREF_RESET;
            rdiv_reg <= RDIV_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_VREF) begin
                vref_reg <= cfg_wdata[VREF_W-1:0];
            end else if (cfg_index == CFG_RDIV) begin
                rdiv_reg <= cfg_wdata;
            end
        end
    end

    // advance whenever the output register is empty or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ntcl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .adc_code (s_tdata[CODE_W-1:0]),
        .func     (s_tuser[0]),
        .vref     (vref_reg),
        .rdiv     (rdiv_reg),
        .out_valid(f_valid),
        .dividend (f_dividend),
        .divisor  (f_divisor),
        .side     (f_side)
    );

    ntcl_div u_div_ohm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f_valid),
        .dividend (f_dividend),
        .divisor  (f_divisor),
        .in_side  (f_side),
        .out_valid(r_valid),
        .quotient (r_ohm),
        .out_side (r_side)
    );

    ntcl_interp u_interp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (r_valid),
        .ohm      (r_ohm),
        .in_side  (r_side),
        .out_valid(i_valid),
        .dividend (i_dividend),
        .divisor  (i_divisor),
        .side     (i_side)
    );

    ntcl_div u_div_slope (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (i_valid),
        .dividend (i_dividend),
        .divisor  (i_divisor),
        .in_side  (i_side),
        .out_valid(q_valid),
        .quotient (q_quot),
        .out_side (q_side)
    );

    ntcl_convert u_convert (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (q_valid),
        .quotient    (q_quot),
        .in_side     (q_side),
        .out_valid   (m_tvalid),
        .temperature (temp),
        .out_of_range(oor)
    );

    assign m_tdata = {1'b0, temp};
    assign m_tuser = oor;

    `NTCL_ASSERT(a_stall_blocks_input, m_tvalid && !m_tready |-> !s_tready)
    `NTCL_ASSERT(a_reading_in_range,
        m_tvalid && !m_tuser[0] |-> $signed(m_tdata[14:0]) <= 15'sd9999 &&
        $signed(m_tdata[14:0]) >= -15'sd9999)
    `NTCL_ASSERT(a_flag_is_limit,
        m_tvalid && m_tuser[0] |-> $signed(m_tdata[14:0]) == 15'sd9999 ||
        $signed(m_tdata[14:0]) == -15'sd9999)
    `NTCL_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid)

endmodule

/* hdl/ntcl_front.sv */
`timescale 1ns / 1ps
// Front end: ADC code to millivolts, then divider numerator and denominator.
// Depends on ntcl_pkg.
module ntcl_front import ntcl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [CODE_W-1:0] adc_code,
    input  logic              func,
    input  logic [VREF_W-1:0] vref,
    input  logic [RDIV_W-1:0] rdiv,
    output logic              out_valid,
    output logic [NUM_W-1:0]  dividend,
    output logic [DEN_W-1:0]  divisor,
    output side_t             side
);

    logic [CODE_W+VREF_W-1:0] prod1;
    logic [MV_W-1:0]          mv_next;
    logic [MV_W-1:0]          mv_reg;
    logic                     func1_reg;
    logic                     valid1_reg;
    logic                     valid2_reg;
    logic [VREF_W-1:0]        diff;
    logic [NUM_W-1:0]         num_next;
    logic [DEN_W-1:0]         den_next;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    side_t                    side_next;
    side_t                    side_reg;

    assign prod1   = {{VREF_W{1'b0}}, adc_code} * {{CODE_W{1'b0}}, vref};
    assign mv_next = prod1[ADC_SHIFT +: MV_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mv_reg    <= mv_next;
            func1_reg <= func;
            num_reg   <= num_next;
            den_reg   <= den_next;
            side_reg  <= side_next;
        end
    end

    always_comb begin
        diff           = vref - mv_reg;
        num_next       = NUM_W'(mv_reg) * NUM_W'(rdiv);
        den_next       = DEN_W'(diff) * DEN_W'(DEN_SCALE);
        side_next      = '0;
        side_next.func = func1_reg;
        // open divider or zero reference reads as infinitely cold
        side_next.cold = (mv_reg >= vref);
    end

    assign out_valid = valid2_reg;
    assign dividend  = num_reg;
    assign divisor   = den_reg;
    assign side      = side_reg;

endmodule

/* hdl/ntcl_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, side band carried along.
// Depends on ntcl_pkg.
module ntcl_div import ntcl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [QUO_W-1:0] quotient,
    output side_t            out_side
);

    logic [REM_W-2:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [NUM_W-1:0] dvd_reg  [QUO_W];
    logic [DEN_W-1:0] dvs_reg  [QUO_W];
    side_t            side_reg [QUO_W];
    logic             vld_reg  [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [REM_W-2:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] dvd_in;
        logic [DEN_W-1:0] dvs_in;
        side_t            side_in;
        logic             vld_in;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] diff;
        logic             take;

        if (j == 0) begin : g_first
            // high dividend bits stay below the divisor for every legal operand
            assign rem_in  = (REM_W-1)'(dividend[NUM_W-1:QUO_W]);
            assign quo_in  = '0;
            assign dvd_in  = dividend;
            assign dvs_in  = divisor;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign dvd_in  = dvd_reg[j-1];
            assign dvs_in  = dvs_reg[j-1];
            assign side_in = side_reg[j-1];
            assign vld_in  = vld_reg[j-1];
        end

        assign trial = {rem_in, dvd_in[QUO_W-1-j]};
        assign take  = (trial >= {1'b0, dvs_in});
        assign diff  = trial - {1'b0, dvs_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= take ? diff[REM_W-2:0] : trial[REM_W-2:0];
                quo_reg[j]  <= {quo_in[QUO_W-2:0], take};
                dvd_reg[j]  <= dvd_in;
                dvs_reg[j]  <= dvs_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quotient  = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

/* hdl/ntcl_interp.sv */
`timescale 1ns / 1ps
// Table search and interpolation set-up: segment, offset from its cold end,
// scaled numerator and segment span for the second divider. Depends on ntcl_pkg.
module ntcl_interp import ntcl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [QUO_W-1:0] ohm,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [NUM_W-1:0] dividend,
    output logic [DEN_W-1:0] divisor,
    output side_t            side
);

    logic                    hot;
    logic [SEG_W-1:0]        seg;
    logic [SEG_W-1:0]        seg_m1;
    logic signed [QUO_W:0]   x_next;
    logic signed [QUO_W:0]   x_reg;
    side_t                   side1_next;
    side_t                   side1_reg;
    logic                    valid1_reg;
    logic                    valid2_reg;
    logic                    neg;
    logic [QUO_W:0]          x_negated;
    logic [QUO_W-1:0]        mag;
    logic [SEG_W-1:0]        seg1_m1;
    logic [NUM_W-1:0]        num_next;
    logic [DEN_W-1:0]        den_next;
    side_t                   side2_next;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    side_t                   side2_reg;

    // first entry from 1 upward whose resistance is below the reading
    always_comb begin
        hot = 1'b1;
        seg = SEG_W'(1);
        for (int i = TABLE_ENTRIES - 1; i >= 1; i--) begin
            if (QUO_W'(RT_OHM[i]) < ohm) begin
                hot = 1'b0;
                seg = SEG_W'(i);
            end
        end
        seg_m1         = seg - SEG_W'(1);
        x_next         = $signed({1'b0, QUO_W'(RT_OHM[seg_m1])}) - $signed({1'b0, ohm});
        side1_next     = in_side;
        side1_next.hot = hot;
        side1_next.seg = seg;
    end

    always_comb begin
        neg            = x_reg[QUO_W];
        x_negated      = -x_reg;
        mag            = neg ? x_negated[QUO_W-1:0] : x_reg[QUO_W-1:0];
        seg1_m1        = side1_reg.seg - SEG_W'(1);
        num_next       = NUM_W'(mag) * NUM_W'(SLOPE_SCALE);
        den_next       = DEN_W'(RT_OHM[seg1_m1] - RT_OHM[side1_reg.seg]);
        side2_next     = side1_reg;
        side2_next.neg = neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= x_next;
            side1_reg <= side1_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            side2_reg <= side2_next;
        end
    end

    assign out_valid = valid2_reg;
    assign dividend  = num_reg;
    assign divisor   = den_reg;
    assign side      = side2_reg;

endmodule

/* hdl/ntcl_convert.sv */
`timescale 1ns / 1ps
// Back end: hundredths from the slope quotient, unit conversion by reciprocal
// multiply, limits and the output register. Depends on ntcl_pkg.
module ntcl_convert import ntcl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [QUO_W-1:0]  quotient,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [TEMP_W-1:0] temperature,
    output logic              out_of_range
);

    logic [QC_W-1:0]         qc;
    logic signed [H_W-1:0]   qs;
    logic [SEG_W-1:0]        seg_m1;
    logic signed [H_W-1:0]   t0;
    logic signed [H_W-1:0]   h_next;
    logic signed [H_W-1:0]   h_reg;
    side_t                   side1_reg;
    logic signed [V_W-1:0]   hx;
    logic signed [V_W-1:0]   v;
    logic [V_W-1:0]          v_negated;
    logic [V_W-2:0]          n_next;
    logic [V_W-2:0]          n_reg;
    logic                    vneg_reg;
    side_t                   side2_reg;
    logic [PROD_W-1:0]       prod_next;
    logic [PROD_W-1:0]       prod_reg;
    logic                    vneg3_reg;
    side_t                   side3_reg;
    logic [MAG_W-1:0]        mag;
    logic signed [MAG_W:0]   tval;
    logic [TEMP_W-1:0]       temp_next;
    logic                    oor_next;
    logic                    valid1_reg;
    logic                    valid2_reg;
    logic                    valid3_reg;
    logic                    valid4_reg;
    logic [TEMP_W-1:0]       temp_reg;
    logic                    oor_reg;

    // clamp deep cold extrapolation; it saturates in either unit anyway
    always_comb begin
        qc     = (quotient > QUO_W'(Q_CLAMP)) ? QC_W'(Q_CLAMP) : quotient[QC_W-1:0];
        qs     = $signed({{(H_W-QC_W){1'b0}}, qc});
        seg_m1 = in_side.seg - SEG_W'(1);
        t0     = H_W'(RT_DEG[seg_m1]) * HUND_S;
        h_next = in_side.neg ? (t0 - qs) : (t0 + qs);
    end

    always_comb begin
        hx        = V_W'(h_reg);
        v         = side1_reg.func ? (hx * NINE_S + F_OFF_S) : hx;
        v_negated = -v;
        n_next    = v[V_W-1] ? v_negated[V_W-2:0] : v[V_W-2:0];
    end

    assign prod_next = PROD_W'(n_reg) *
                       PROD_W'(side2_reg.func ? RCP_FAHR : RCP_TENTHS);

    always_comb begin
        mag  = prod_reg[RCP_SHIFT +: MAG_W];
        tval = vneg3_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (side3_reg.cold) begin
            temp_next = TEMP_W'(-LIMIT_S);
            oor_next  = 1'b1;
        end else if (side3_reg.hot) begin
            temp_next = TEMP_W'(LIMIT_S);
            oor_next  = 1'b1;
        end else if (tval < -LIMIT_S) begin
            temp_next = TEMP_W'(-LIMIT_S);
            oor_next  = 1'b1;
        end else if (tval > LIMIT_S) begin
            temp_next = TEMP_W'(LIMIT_S);
            oor_next  = 1'b1;
        end else begin
            temp_next = TEMP_W'(tval);
            oor_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg     <= h_next;
            side1_reg <= in_side;
            n_reg     <= n_next;
            vneg_reg  <= v[V_W-1];
            side2_reg <= side1_reg;
            prod_reg  <= prod_next;
            vneg3_reg <= vneg_reg;
            side3_reg <= side2_reg;
            temp_reg  <= temp_next;
            oor_reg   <= oor_next;
        end
    end

    assign out_valid    = valid4_reg;
    assign temperature  = temp_reg;
    assign out_of_range = oor_reg;

endmodule
